/* sv/top_level_statement_splitter_macros.svh */
// ============================================================================
// Statement splitter assertion macros
// Shared assertion forms for the statement splitter checker.
// ============================================================================
`ifndef TOP_LEVEL_STATEMENT_SPLITTER_MACROS_SVH
`define TOP_LEVEL_STATEMENT_SPLITTER_MACROS_SVH

// Assertion that is checked only outside of reset.
`define TLSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define TLSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* sv/tlss_pkg.sv */
// ============================================================================
// Statement splitter package
// Types, byte codes and helper functions shared by the splitter modules.
// ============================================================================
package tlss_pkg;

    // Default widths of the position counter and the brace depth counter.
    localparam int OFFSET_BITS_DEF = 32;
    localparam int DEPTH_BITS_DEF  = 16;

    // Entries in the queue between scanner and output stage (power of two).
    localparam int QUEUE_DEPTH = 4;

    // Byte codes recognized by the scanner.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;

    // Lexical mode of the scanner.
    typedef enum logic [1:0] {
        MODE_CODE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_LINE   = 2'd2,
        MODE_BLOCK  = 2'd3
    } mode_t;

    // One finished chunk.
    typedef struct packed {
        logic [31:0] chunk_begin;
        logic [31:0] chunk_stop;
        logic [31:0] begin_line;
        logic [31:0] begin_column;
    } chunk_t;

    // All chunks caused by one input byte (one or two).
    typedef struct packed {
        logic   two;
        chunk_t c0;
        chunk_t c1;
    } pair_t;

    // Blank bytes that are skipped after a closing brace.
    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    // White space that may precede a chunk.
    function automatic logic is_space(input logic [7:0] b);
        return is_blank(b) || (b == CH_VT) || (b == CH_FF);
    endfunction

endpackage

/* sv/tlss_front.sv */
// ============================================================================
// Statement splitter scanner
// Tracks lexical mode, brace depth and position, and forms the chunks that
// each accepted byte closes.
// ============================================================================
module tlss_front #(
    parameter int OFFSET_BITS = tlss_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = tlss_pkg::DEPTH_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      text_byte,
    input  logic            final_byte,
    output logic            push_valid,
    output tlss_pkg::pair_t push_data,
    input  logic            push_ready
);
    import tlss_pkg::*;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [31:0]            line_reg, line_next;
    logic [31:0]            col_reg, col_next;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next;
    mode_t                  mode_reg, mode_next;
    logic                   esc_reg, esc_next;
    logic                   star_reg, star_next;
    logic                   slash_reg, slash_next;
    logic                   close_reg, close_next;
    logic [OFFSET_BITS-1:0] pstop_reg, pstop_next;
    logic                   open_reg, open_next;
    logic [OFFSET_BITS-1:0] obegin_reg, obegin_next;
    logic [31:0]            oline_reg, oline_next;
    logic [31:0]            ocol_reg, ocol_next;

    logic                   accept;
    logic [1:0]             cnt;
    chunk_t                 rec0, rec1;
    logic                   done;
    logic                   handled;
    logic [OFFSET_BITS-1:0] pos_inc;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = push_ready;
    assign pos_inc  = pos_reg + 1'b1;

    // Build a chunk record from the open chunk and a stop offset.
    function automatic chunk_t make_chunk(input logic [OFFSET_BITS-1:0] b,
                                          input logic [OFFSET_BITS-1:0] s,
                                          input logic [31:0] l,
                                          input logic [31:0] c);
        chunk_t r;
        r.chunk_begin  = 32'(b);
        r.chunk_stop   = 32'(s);
        r.begin_line   = l;
        r.begin_column = c;
        return r;
    endfunction

    // Next state and emitted chunks for the byte on the input.
    always_comb begin
        pos_next    = pos_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        depth_next  = depth_reg;
        mode_next   = mode_reg;
        esc_next    = esc_reg;
        star_next   = star_reg;
        slash_next  = slash_reg;
        close_next  = close_reg;
        pstop_next  = pstop_reg;
        open_next   = open_reg;
        obegin_next = obegin_reg;
        oline_next  = oline_reg;
        ocol_next   = ocol_reg;
        rec0        = '0;
        rec1        = '0;
        cnt         = 2'd0;
        done        = 1'b0;
        handled     = 1'b0;

        // A held closing brace decides first.
        if (close_reg) begin
            if (is_blank(text_byte)) begin
                done = 1'b1;
            end else if (text_byte == CH_SEMI) begin
                rec0       = make_chunk(obegin_reg, pos_inc, oline_reg, ocol_reg);
                cnt        = 2'd1;
                open_next  = 1'b0;
                close_next = 1'b0;
                done       = 1'b1;
            end else begin
                rec0       = make_chunk(obegin_reg, pstop_reg, oline_reg, ocol_reg);
                cnt        = 2'd1;
                open_next  = 1'b0;
                close_next = 1'b0;
            end
        end

        // Lexical processing of the byte.
        if (!done) begin
            case (mode_reg)
                MODE_LINE: begin
                    if (text_byte == CH_LF) mode_next = MODE_CODE;
                end
                MODE_BLOCK: begin
                    if (star_reg && text_byte == CH_SLASH) begin
                        mode_next = MODE_CODE;
                        star_next = 1'b0;
                    end else begin
                        star_next = (text_byte == CH_STAR);
                    end
                end
                MODE_STRING: begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                    end else if (text_byte == CH_BSLASH) begin
                        esc_next = 1'b1;
                    end else if (text_byte == CH_QUOTE) begin
                        mode_next = MODE_CODE;
                    end
                end
                default: begin
                    // A slash seen last byte may open a comment now.
                    if (slash_reg) begin
                        slash_next = 1'b0;
                        if (text_byte == CH_SLASH) begin
                            mode_next = MODE_LINE;
                            handled   = 1'b1;
                        end else if (text_byte == CH_STAR) begin
                            mode_next = MODE_BLOCK;
                            star_next = 1'b0;
                            handled   = 1'b1;
                        end
                    end
                    if (!handled && !(!open_next && is_space(text_byte))) begin
                        if (!open_next) begin
                            open_next   = 1'b1;
                            obegin_next = pos_reg;
                            oline_next  = line_reg;
                            ocol_next   = col_reg;
                        end
                        if (text_byte == CH_SLASH) begin
                            slash_next = 1'b1;
                        end else if (text_byte == CH_QUOTE) begin
                            mode_next = MODE_STRING;
                            esc_next  = 1'b0;
                        end else if (text_byte == CH_LBRACE) begin
                            if (depth_next != '1) depth_next = depth_next + 1'b1;
                        end else if (text_byte == CH_RBRACE) begin
                            if (depth_next != '0) depth_next = depth_next - 1'b1;
                            if (depth_next == '0) begin
                                close_next = 1'b1;
                                pstop_next = pos_inc;
                            end
                        end else if (text_byte == CH_SEMI && depth_next == '0) begin
                            if (cnt == 2'd0) begin
                                rec0 = make_chunk(obegin_next, pos_inc, oline_next, ocol_next);
                            end else begin
                                rec1 = make_chunk(obegin_next, pos_inc, oline_next, ocol_next);
                            end
                            cnt        = cnt + 2'd1;
                            open_next  = 1'b0;
                            close_next = 1'b0;
                        end
                    end
                end
            endcase
        end

        // Position, line and column advance on every byte.
        pos_next = pos_inc;
        if (text_byte == CH_LF) begin
            line_next = line_reg + 32'd1;
            col_next  = 32'd1;
        end else begin
            col_next = col_reg + 32'd1;
        end

        // The last byte flushes the open chunk and restarts the text.
        if (final_byte) begin
            if (close_next || open_next) begin
                if (cnt == 2'd0) begin
                    rec0 = make_chunk(obegin_next, close_next ? pstop_next : pos_next,
                                      oline_next, ocol_next);
                end else begin
                    rec1 = make_chunk(obegin_next, close_next ? pstop_next : pos_next,
                                      oline_next, ocol_next);
                end
                cnt = cnt + 2'd1;
            end
            pos_next    = '0;
            line_next   = 32'd1;
            col_next    = 32'd1;
            depth_next  = '0;
            mode_next   = MODE_CODE;
            esc_next    = 1'b0;
            star_next   = 1'b0;
            slash_next  = 1'b0;
            close_next  = 1'b0;
            pstop_next  = '0;
            open_next   = 1'b0;
            obegin_next = '0;
            oline_next  = 32'd1;
            ocol_next   = 32'd1;
        end
    end

    // Hand the chunks of this byte to the queue as one transaction.
    assign push_valid     = accept && (cnt != 2'd0);
    assign push_data.two  = (cnt == 2'd2);
    assign push_data.c0   = rec0;
    assign push_data.c1   = rec1;

    // Scanner state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            line_reg   <= 32'd1;
            col_reg    <= 32'd1;
            depth_reg  <= '0;
            mode_reg   <= MODE_CODE;
            esc_reg    <= 1'b0;
            star_reg   <= 1'b0;
            slash_reg  <= 1'b0;
            close_reg  <= 1'b0;
            pstop_reg  <= '0;
            open_reg   <= 1'b0;
            obegin_reg <= '0;
            oline_reg  <= 32'd1;
            ocol_reg   <= 32'd1;
        end else if (accept) begin
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            depth_reg  <= depth_next;
            mode_reg   <= mode_next;
            esc_reg    <= esc_next;
            star_reg   <= star_next;
            slash_reg  <= slash_next;
            close_reg  <= close_next;
            pstop_reg  <= pstop_next;
            open_reg   <= open_next;
            obegin_reg <= obegin_next;
            oline_reg  <= oline_next;
            ocol_reg   <= ocol_next;
        end
    end

endmodule

/* sv/tlss_queue.sv */
// ============================================================================
// Statement splitter queue
// Short first-in first-out queue of chunk groups between scanner and output.
// ============================================================================
module tlss_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    input  tlss_pkg::pair_t push_data,
    output logic            push_ready,
    output logic            pop_valid,
    output tlss_pkg::pair_t pop_data,
    input  logic            pop_ready
);
    import tlss_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pair_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Storage write.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/tlss_back.sv */
// ============================================================================
// Statement splitter output stage
// Holds one chunk group in a register and delivers its chunks one per
// transaction on the result channel.
// ============================================================================
module tlss_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            pop_valid,
    input  tlss_pkg::pair_t pop_data,
    output logic            pop_ready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [127:0]    m_tdata,
    output logic            m_tlast
);
    import tlss_pkg::*;

    pair_t  pair_reg;
    logic   valid_reg, valid_next;
    logic   idx_reg, idx_next;
    logic   last_now;
    chunk_t cur;

    // The current chunk is the last of its group when the index reaches it.
    assign last_now  = (idx_reg == pair_reg.two);
    assign cur       = idx_reg ? pair_reg.c1 : pair_reg.c0;
    assign pop_ready = !valid_reg || (m_tready && last_now);

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_now;
    assign m_tdata  = {cur.begin_column, cur.begin_line, cur.chunk_stop, cur.chunk_begin};

    // Group register: reload when empty or when its last chunk leaves.
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (pop_ready && pop_valid) begin
            valid_next = 1'b1;
            idx_next   = 1'b0;
        end else if (valid_reg && m_tready) begin
            if (last_now) begin
                valid_next = 1'b0;
            end else begin
                idx_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ready && pop_valid) begin
            pair_reg <= pop_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* sv/top_level_statement_splitter.sv */
// ============================================================================
// Top-level statement splitter
// Splits a byte stream of source text into top-level chunks and reports the
// offsets, line and column of each one.
// ============================================================================
//
//  Channel  | Direction | tdata                         | tlast
//  ---------+-----------+-------------------------------+--------------
//  s_       | in        | text_byte                     | final_byte
//  m_       | out       | begin, stop, line, column     | last_of_run
//
// One byte is taken every cycle while the queue has room; the scanner keeps
// all lexical state in registers updated in that same cycle.
// A byte causes zero, one or two chunks; each chunk is a separate transfer on the
// result channel, so bytes that close two chunks are limited by that port.
// Reset is synchronous and clears the scanner, queue and output stage.
// A stall on the result channel fills the four-entry queue, then s_tready drops.
module top_level_statement_splitter #(
    parameter int OFFSET_BITS = tlss_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = tlss_pkg::DEPTH_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] text_byte
    input  logic         s_tlast,   // final_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // chunk_begin, chunk_stop, begin_line, begin_column
    output logic         m_tlast    // last_of_run
);
    import tlss_pkg::*;

    logic  push_valid, push_ready;
    pair_t push_data;
    logic  pop_valid, pop_ready;
    pair_t pop_data;

    // Scanner front end.
    tlss_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .text_byte  (s_tdata),
        .final_byte (s_tlast),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    // Queue between scanner and output stage.
    tlss_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    // Output stage.
    tlss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* sv/tlss_checker.sv */
// ============================================================================
// Statement splitter checker
// Port-level assertions on the splitter, attached to the top level by bind.
// ============================================================================
`include "top_level_statement_splitter_macros.svh"

module tlss_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tlast
);

    // A stalled result keeps its valid and its contents.
    `TLSS_ASSERT(a_m_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // The second chunk of a byte follows its first without a gap.
    `TLSS_ASSERT(a_run_cont, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "gap inside a run of chunks")

    // Reset empties the output stage.
    `TLSS_ASSERT_ALWAYS(a_rst_out, !aresetn |=> !m_tvalid, "result valid after reset")

    // Reset empties the queue, so the input side is ready right after it.
    `TLSS_ASSERT_ALWAYS(a_rst_in, !aresetn |=> s_tready, "input not ready after reset")

endmodule

bind top_level_statement_splitter tlss_checker u_tlss_checker (.*);
